// ===== design/clt_pkg.sv =====
// Shared types and constants for the command-line tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package clt_pkg;

    localparam int MAX_TOKENS = 255;
    localparam int COUNT_CAP_I = (MAX_TOKENS < 255) ? MAX_TOKENS : 255;
    localparam logic [7:0] COUNT_CAP = COUNT_CAP_I[7:0];

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_DQ    = 2'd1,
        MODE_SQ    = 2'd2,
        MODE_SKIP  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2,
        KIND_ERR  = 2'd3
    } t_kind;

    // One queued command: up to three results caused by one input byte.
    typedef struct packed {
        logic [1:0]  num;
        t_kind [2:0] kinds;
        logic [7:0]  data;
        logic [7:0]  total;
    } t_cmd;

endpackage
`default_nettype wire

// ===== design/command_line_tokenizer.sv =====
// Top level of the command-line tokenizer.
// Usage:
//   Slave channel takes one command-line byte per transfer in i_s_tdata; a
//   zero byte ends the line. Master channel gives results: o_m_tuser is the
//   kind (token byte, token end, line done, line error), o_m_tdata carries
//   the token byte (low byte) and the token count of the line (high byte),
//   and o_m_tlast marks the final result caused by one input byte.
//   Bytes that cause no result (quotes, backslash, skipped bytes) give none.
// Path: each byte's command is queued, then registered in the sequencer.
// One byte per cycle while i_m_tready is high and each byte gives one
//   result; a byte with n results holds the sequencer for n transfers on
//   the single result port. A four-entry command queue absorbs short bursts.
// Reset: synchronous, active low; lexer returns to plain mode with zero
//   count and the queue and output are emptied.
// Stall: when i_m_tready is low the current result holds; the front end
//   keeps taking bytes until the command queue fills, then drops o_s_tready.
`timescale 1ns / 1ps
`default_nettype none
module command_line_tokenizer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] in_byte
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] out_byte, [15:8] token_total
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast
);

    logic           q_push, q_pop, q_full, q_empty;
    clt_pkg::t_cmd  f_cmd, q_head;
    clt_pkg::t_kind b_kind;
    logic [7:0]     b_byte, b_total;

    clt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_byte  (i_s_tdata),
        .i_q_full(q_full),
        .o_ready (o_s_tready),
        .o_push  (q_push),
        .o_cmd   (f_cmd)
    );

    clt_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (f_cmd),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_head (q_head)
    );

    clt_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(q_empty),
        .i_head (q_head),
        .o_pop  (q_pop),
        .o_valid(o_m_tvalid),
        .i_ready(i_m_tready),
        .o_kind (b_kind),
        .o_byte (b_byte),
        .o_total(b_total),
        .o_last (o_m_tlast)
    );

    assign o_m_tdata = {b_total, b_byte};
    assign o_m_tuser = b_kind;

endmodule
`default_nettype wire

// ===== design/clt_front.sv =====
// Front end: lexer state and per-byte classification into result commands.
`timescale 1ns / 1ps
`default_nettype none
module clt_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire  [7:0]       i_byte,
    input  wire              i_q_full,
    output logic             o_ready,
    output logic             o_push,
    output clt_pkg::t_cmd    o_cmd
);

    clt_pkg::t_mode r_mode, n_mode;
    logic           r_esc, n_esc;
    logic           r_open, n_open;
    logic [7:0]     r_count, n_count;
    logic           accept;
    logic           is_space, is_sep, is_end;
    logic [7:0]     cnt_closed;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v < clt_pkg::COUNT_CAP) ? v + 8'd1 : v;
    endfunction

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign is_space = (i_byte == clt_pkg::CH_SPACE) ||
                      (i_byte >= clt_pkg::CH_TAB && i_byte <= clt_pkg::CH_CR);
    assign is_sep   = (i_byte == clt_pkg::CH_LPAREN) || (i_byte == clt_pkg::CH_RPAREN) ||
                      (i_byte == clt_pkg::CH_EQUAL)  || (i_byte == clt_pkg::CH_COMMA);
    assign is_end   = (i_byte == clt_pkg::CH_NUL) || (i_byte == clt_pkg::CH_SEMI);
    assign cnt_closed = r_open ? sat_inc(r_count) : r_count;

    // next lexer state
    always_comb begin
        n_mode  = r_mode;
        n_esc   = r_esc;
        n_open  = r_open;
        n_count = r_count;
        if (r_mode == clt_pkg::MODE_SKIP) begin
            if (i_byte == clt_pkg::CH_NUL) begin
                n_mode = clt_pkg::MODE_PLAIN;
            end
        end else if (r_esc) begin
            if (i_byte == clt_pkg::CH_NUL) begin
                n_mode  = clt_pkg::MODE_PLAIN;
                n_esc   = 1'b0;
                n_open  = 1'b0;
                n_count = '0;
            end else begin
                n_esc  = 1'b0;
                n_open = 1'b1;
            end
        end else if (r_mode == clt_pkg::MODE_DQ || r_mode == clt_pkg::MODE_SQ) begin
            if ((r_mode == clt_pkg::MODE_DQ && i_byte == clt_pkg::CH_DQUOTE) ||
                (r_mode == clt_pkg::MODE_SQ && i_byte == clt_pkg::CH_SQUOTE)) begin
                n_mode = clt_pkg::MODE_PLAIN;
            end else if (i_byte == clt_pkg::CH_BSLASH) begin
                n_esc = 1'b1;
            end else if (i_byte == clt_pkg::CH_NUL) begin
                n_mode  = clt_pkg::MODE_PLAIN;
                n_open  = 1'b0;
                n_count = '0;
            end else begin
                n_open = 1'b1;
            end
        end else begin
            priority if (is_space) begin
                n_open  = 1'b0;
                n_count = cnt_closed;
            end else if (is_end) begin
                n_open  = 1'b0;
                n_count = '0;
                n_mode  = (i_byte == clt_pkg::CH_NUL) ? clt_pkg::MODE_PLAIN
                                                      : clt_pkg::MODE_SKIP;
            end else if (is_sep) begin
                n_open  = 1'b0;
                n_count = sat_inc(cnt_closed);
            end else if (i_byte == clt_pkg::CH_DQUOTE) begin
                n_mode = clt_pkg::MODE_DQ;
            end else if (i_byte == clt_pkg::CH_SQUOTE) begin
                n_mode = clt_pkg::MODE_SQ;
            end else if (i_byte == clt_pkg::CH_BSLASH) begin
                n_esc = 1'b1;
            end else begin
                n_open = 1'b1;
            end
        end
    end

    // result command for this byte
    always_comb begin
        o_cmd.num   = 2'd0;
        o_cmd.kinds = '{clt_pkg::KIND_BYTE, clt_pkg::KIND_BYTE, clt_pkg::KIND_BYTE};
        o_cmd.data  = i_byte;
        o_cmd.total = cnt_closed;
        if (r_mode == clt_pkg::MODE_SKIP) begin
            o_cmd.num = 2'd0;
        end else if (r_esc || r_mode == clt_pkg::MODE_DQ || r_mode == clt_pkg::MODE_SQ) begin
            if (i_byte == clt_pkg::CH_NUL) begin
                o_cmd.num      = 2'd1;
                o_cmd.kinds[0] = clt_pkg::KIND_ERR;
            end else if (r_esc) begin
                o_cmd.num = 2'd1;
            end else if ((r_mode == clt_pkg::MODE_DQ && i_byte == clt_pkg::CH_DQUOTE) ||
                         (r_mode == clt_pkg::MODE_SQ && i_byte == clt_pkg::CH_SQUOTE) ||
                         i_byte == clt_pkg::CH_BSLASH) begin
                o_cmd.num = 2'd0;
            end else begin
                o_cmd.num = 2'd1;
            end
        end else begin
            priority if (is_space) begin
                o_cmd.num      = {1'b0, r_open};
                o_cmd.kinds[0] = clt_pkg::KIND_END;
            end else if (is_end) begin
                if (r_open) begin
                    o_cmd.num      = 2'd2;
                    o_cmd.kinds[0] = clt_pkg::KIND_END;
                    o_cmd.kinds[1] = clt_pkg::KIND_DONE;
                end else begin
                    o_cmd.num      = 2'd1;
                    o_cmd.kinds[0] = clt_pkg::KIND_DONE;
                end
            end else if (is_sep) begin
                if (r_open) begin
                    o_cmd.num      = 2'd3;
                    o_cmd.kinds[0] = clt_pkg::KIND_END;
                    o_cmd.kinds[1] = clt_pkg::KIND_BYTE;
                    o_cmd.kinds[2] = clt_pkg::KIND_END;
                end else begin
                    o_cmd.num      = 2'd2;
                    o_cmd.kinds[0] = clt_pkg::KIND_BYTE;
                    o_cmd.kinds[1] = clt_pkg::KIND_END;
                end
            end else if (i_byte == clt_pkg::CH_DQUOTE || i_byte == clt_pkg::CH_SQUOTE ||
                         i_byte == clt_pkg::CH_BSLASH) begin
                o_cmd.num = 2'd0;
            end else begin
                o_cmd.num = 2'd1;
            end
        end
    end

    assign o_push = accept && (o_cmd.num != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= clt_pkg::MODE_PLAIN;
            r_esc   <= 1'b0;
            r_open  <= 1'b0;
            r_count <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_esc   <= n_esc;
            r_open  <= n_open;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== design/clt_queue.sv =====
// Short command queue between front end and result sequencer.
`timescale 1ns / 1ps
`default_nettype none
module clt_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  clt_pkg::t_cmd    i_cmd,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_empty,
    output clt_pkg::t_cmd    o_head
);

    clt_pkg::t_cmd                r_mem [clt_pkg::QDEPTH];
    logic [clt_pkg::QPTR_W-1:0]   r_wptr, r_rptr;
    logic [clt_pkg::QCNT_W-1:0]   r_cnt;
    logic                         do_pop;

    assign o_full  = (r_cnt == clt_pkg::QCNT_W'(clt_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/clt_back.sv =====
// Result sequencer: expands each queued command into its result transfers.
`timescale 1ns / 1ps
`default_nettype none
module clt_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_empty,
    input  clt_pkg::t_cmd    i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output clt_pkg::t_kind   o_kind,
    output logic [7:0]       o_byte,
    output logic [7:0]       o_total,
    output logic             o_last
);

    clt_pkg::t_cmd r_cmd;
    logic [1:0]    r_slot;
    logic          r_busy;
    logic          xfer;

    always_comb begin
        unique case (r_slot)
            2'd0:    o_kind = r_cmd.kinds[0];
            2'd1:    o_kind = r_cmd.kinds[1];
            2'd2:    o_kind = r_cmd.kinds[2];
            default: o_kind = clt_pkg::KIND_BYTE;
        endcase
    end

    assign o_valid = r_busy;
    assign o_byte  = (o_kind == clt_pkg::KIND_BYTE) ? r_cmd.data : 8'd0;
    assign o_total = (o_kind == clt_pkg::KIND_DONE) ? r_cmd.total : 8'd0;
    assign o_last  = (r_slot == r_cmd.num - 2'd1);
    assign xfer    = r_busy && i_ready;
    assign o_pop   = !i_empty && (!r_busy || (xfer && o_last));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_slot <= '0;
        end else if (xfer) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end else begin
                r_slot <= r_slot + 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/clt_checker.sv =====
// Port-level checks for the command-line tokenizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module clt_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [15:0] o_m_tdata,
    input wire [1:0]  o_m_tuser,
    input wire        o_m_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != clt_pkg::KIND_BYTE) |-> (o_m_tdata[7:0] == 8'd0))
        else $error("out_byte nonzero on non-byte result");

    a_total_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != clt_pkg::KIND_DONE) |-> (o_m_tdata[15:8] == 8'd0))
        else $error("token_total nonzero outside line done");

    a_line_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == clt_pkg::KIND_DONE || o_m_tuser == clt_pkg::KIND_ERR)
        |-> o_m_tlast)
        else $error("line done or error not final result of its byte");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser),
    .o_m_tlast (o_m_tlast)
);
`default_nettype wire
